// ===== hw/rtl/bmrect_pkg.sv =====
// Shared constants, command type and sequencer states of the bitmap rectangle core.
package bmrect_pkg;

  localparam int GRID_SIDE = 1024;
  localparam int WORD_BITS = 64;
  localparam int IN_W      = 10;
  localparam int OP_W      = 2;
  localparam int OUT_W     = 21;

  localparam int ROW_W     = $clog2(GRID_SIDE);
  localparam int ROW_WORDS = (GRID_SIDE + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = ROW_W + WIDX_W;
  localparam int MEM_DEPTH = GRID_SIDE * (2 ** WIDX_W);
  localparam int TOTAL_W   = $clog2(GRID_SIDE * GRID_SIDE + 1);
  localparam int PC_W      = $clog2(WORD_BITS + 1);
  localparam int CMP_W     = (IN_W > ROW_W) ? IN_W : ROW_W;
  localparam int SAT_W     = (TOTAL_W > OUT_W) ? TOTAL_W : OUT_W;

  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int RQ_DEPTH  = 2;
  localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);

  localparam logic [CMP_W-1:0] LAST_IDX  = CMP_W'(GRID_SIDE - 1);
  localparam logic [BIT_W-1:0] BIT_MAX   = BIT_W'(WORD_BITS - 1);
  localparam logic [OUT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_SET    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_INVERT = 2'd2
  } op_t;

  typedef struct packed {
    logic              live;
    op_t               op;
    logic [ROW_W-1:0]  row_lo;
    logic [ROW_W-1:0]  row_hi;
    logic [WIDX_W-1:0] word_lo;
    logic [WIDX_W-1:0] word_hi;
    logic [BIT_W-1:0]  bit_lo;
    logic [BIT_W-1:0]  bit_hi;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

endpackage

// ===== hw/rtl/bmrect_front.sv =====
// Front end: accepts rectangle commands, clamps the corners and classifies them.
module bmrect_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [bmrect_pkg::OP_W-1:0] in_operation,
  input  logic [bmrect_pkg::IN_W-1:0] in_first_low,
  input  logic [bmrect_pkg::IN_W-1:0] in_second_low,
  input  logic [bmrect_pkg::IN_W-1:0] in_first_high,
  input  logic [bmrect_pkg::IN_W-1:0] in_second_high,
  input  logic                     clearing,
  input  logic                     cq_full,
  output logic                     cq_push,
  output bmrect_pkg::cmd_t         cq_cmd
);

  logic                          fr_valid_r;
  logic                          fr_valid_nxt;
  bmrect_pkg::cmd_t              fr_cmd_r;
  bmrect_pkg::cmd_t              cls_cmd;
  logic                          accept;
  logic                          op_ok;
  logic [bmrect_pkg::CMP_W-1:0]  r0_x;
  logic [bmrect_pkg::CMP_W-1:0]  c0_x;
  logic [bmrect_pkg::CMP_W-1:0]  r1_x;
  logic [bmrect_pkg::CMP_W-1:0]  c1_x;
  logic [bmrect_pkg::CMP_W-1:0]  r1_c;
  logic [bmrect_pkg::CMP_W-1:0]  c1_c;
  logic [bmrect_pkg::ROW_W-1:0]  col_lo;
  logic [bmrect_pkg::ROW_W-1:0]  col_hi;

  assign in_full      = clearing | (fr_valid_r & cq_full);
  assign accept       = in_push & ~in_full;
  assign cq_push      = fr_valid_r & ~cq_full;
  assign cq_cmd       = fr_cmd_r;
  assign fr_valid_nxt = accept | (fr_valid_r & cq_full);

  always_comb begin
    op_ok  = (in_operation == bmrect_pkg::OP_SET) ||
             (in_operation == bmrect_pkg::OP_CLEAR) ||
             (in_operation == bmrect_pkg::OP_INVERT);
    r0_x   = bmrect_pkg::CMP_W'(in_first_low);
    c0_x   = bmrect_pkg::CMP_W'(in_second_low);
    r1_x   = bmrect_pkg::CMP_W'(in_first_high);
    c1_x   = bmrect_pkg::CMP_W'(in_second_high);
    r1_c   = (r1_x > bmrect_pkg::LAST_IDX) ? bmrect_pkg::LAST_IDX : r1_x;
    c1_c   = (c1_x > bmrect_pkg::LAST_IDX) ? bmrect_pkg::LAST_IDX : c1_x;
    col_lo = bmrect_pkg::ROW_W'(c0_x);
    col_hi = bmrect_pkg::ROW_W'(c1_c);

    cls_cmd.live    = op_ok && (r0_x <= r1_c) && (c0_x <= c1_c);
    cls_cmd.op      = op_ok ? bmrect_pkg::op_t'(in_operation) : bmrect_pkg::OP_SET;
    cls_cmd.row_lo  = bmrect_pkg::ROW_W'(r0_x);
    cls_cmd.row_hi  = bmrect_pkg::ROW_W'(r1_c);
    cls_cmd.word_lo = bmrect_pkg::WIDX_W'(col_lo / bmrect_pkg::WORD_BITS);
    cls_cmd.word_hi = bmrect_pkg::WIDX_W'(col_hi / bmrect_pkg::WORD_BITS);
    cls_cmd.bit_lo  = bmrect_pkg::BIT_W'(col_lo % bmrect_pkg::WORD_BITS);
    cls_cmd.bit_hi  = bmrect_pkg::BIT_W'(col_hi % bmrect_pkg::WORD_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fr_cmd_r <= cls_cmd;
    end
  end

endmodule

// ===== hw/rtl/bmrect_cmd_fifo.sv =====
// Short command queue between the front end and the raster sequencer.
module bmrect_cmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  bmrect_pkg::cmd_t cmd_in,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output bmrect_pkg::cmd_t cmd_out
);

  bmrect_pkg::cmd_t               entry_r [bmrect_pkg::CQ_DEPTH];
  logic [bmrect_pkg::CQ_PTR_W-1:0] wr_ptr_r;
  logic [bmrect_pkg::CQ_PTR_W-1:0] rd_ptr_r;
  logic [bmrect_pkg::CQ_PTR_W:0]   count_r;
  logic [bmrect_pkg::CQ_PTR_W:0]   count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (count_r == (bmrect_pkg::CQ_PTR_W + 1)'(bmrect_pkg::CQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign cmd_out = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/bmrect_back.sv =====
// Raster sequencer: clearing pass, word read-modify-write pipeline, lit count and result queue.
module bmrect_back (
  input  logic                         clk,
  input  logic                         rst_n,
  output logic                         clearing,
  input  logic                         cq_empty,
  output logic                         cq_pop,
  input  bmrect_pkg::cmd_t             cq_cmd,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [bmrect_pkg::OUT_W-1:0] out_lit_count
);

  localparam int NCHUNK = (bmrect_pkg::WORD_BITS + 7) / 8;
  localparam int PAD_W  = NCHUNK * 8;

  bmrect_pkg::back_state_t             state_r;
  bmrect_pkg::back_state_t             state_nxt;
  bmrect_pkg::cmd_t                    cur_r;
  logic [bmrect_pkg::ROW_W-1:0]        row_r;
  logic [bmrect_pkg::WIDX_W-1:0]       word_r;
  logic [bmrect_pkg::ADDR_W-1:0]       clr_addr_r;
  logic                                issue;
  logic                                last_word;
  logic                                pipe_busy;
  logic                                res_push;
  logic                                res_full;

  logic [bmrect_pkg::BIT_W-1:0]        lo_bit;
  logic [bmrect_pkg::BIT_W-1:0]        hi_bit;
  logic [bmrect_pkg::WORD_BITS-1:0]    mask;
  logic [bmrect_pkg::WORD_BITS-1:0]    cell_mem_r [bmrect_pkg::MEM_DEPTH];
  logic [bmrect_pkg::WORD_BITS-1:0]    rd_data_r;
  logic                                mem_we;
  logic [bmrect_pkg::ADDR_W-1:0]       mem_wa;
  logic [bmrect_pkg::WORD_BITS-1:0]    mem_wd;

  logic                                s1_valid_r;
  logic [bmrect_pkg::WORD_BITS-1:0]    s1_mask_r;
  logic [bmrect_pkg::ADDR_W-1:0]       s1_addr_r;
  logic [bmrect_pkg::WORD_BITS-1:0]    new_word;
  logic [bmrect_pkg::WORD_BITS-1:0]    gain;
  logic [bmrect_pkg::WORD_BITS-1:0]    loss;

  logic                                s2_valid_r;
  logic [bmrect_pkg::WORD_BITS-1:0]    gain_r;
  logic [bmrect_pkg::WORD_BITS-1:0]    loss_r;
  logic [PAD_W-1:0]                    gain_pad;
  logic [PAD_W-1:0]                    loss_pad;
  logic [3:0]                          gcnt [NCHUNK];
  logic [3:0]                          lcnt [NCHUNK];

  logic                                s3_valid_r;
  logic [3:0]                          gcnt_r [NCHUNK];
  logic [3:0]                          lcnt_r [NCHUNK];
  logic [bmrect_pkg::PC_W-1:0]         g_sum;
  logic [bmrect_pkg::PC_W-1:0]         l_sum;
  logic [bmrect_pkg::TOTAL_W-1:0]      total_r;

  logic [bmrect_pkg::SAT_W-1:0]        total_x;
  logic [bmrect_pkg::OUT_W-1:0]        sat_count;
  logic [bmrect_pkg::OUT_W-1:0]        res_q_r [bmrect_pkg::RQ_DEPTH];
  logic [bmrect_pkg::RQ_PTR_W-1:0]     rq_wr_r;
  logic [bmrect_pkg::RQ_PTR_W-1:0]     rq_rd_r;
  logic [bmrect_pkg::RQ_PTR_W:0]       rq_cnt_r;
  logic                                res_pop;

  assign last_word = (word_r == cur_r.word_hi) && (row_r == cur_r.row_hi);
  assign pipe_busy = s1_valid_r | s2_valid_r | s3_valid_r;
  assign res_full  = (rq_cnt_r == (bmrect_pkg::RQ_PTR_W + 1)'(bmrect_pkg::RQ_DEPTH));
  assign out_empty = (rq_cnt_r == '0);
  assign res_pop   = out_pop & ~out_empty;
  assign out_lit_count = res_q_r[rq_rd_r];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmrect_pkg::BK_CLEAR: begin
        if (clr_addr_r == bmrect_pkg::ADDR_W'(bmrect_pkg::MEM_DEPTH - 1)) begin
          state_nxt = bmrect_pkg::BK_IDLE;
        end
      end
      bmrect_pkg::BK_IDLE: begin
        if (!cq_empty) begin
          state_nxt = cq_cmd.live ? bmrect_pkg::BK_RUN : bmrect_pkg::BK_DONE;
        end
      end
      bmrect_pkg::BK_RUN: begin
        if (last_word) begin
          state_nxt = bmrect_pkg::BK_DRAIN;
        end
      end
      bmrect_pkg::BK_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = bmrect_pkg::BK_DONE;
        end
      end
      bmrect_pkg::BK_DONE: begin
        if (!res_full) begin
          state_nxt = bmrect_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bmrect_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    clearing = 1'b0;
    cq_pop   = 1'b0;
    issue    = 1'b0;
    res_push = 1'b0;
    case (state_r)
      bmrect_pkg::BK_CLEAR: clearing = 1'b1;
      bmrect_pkg::BK_IDLE:  cq_pop   = ~cq_empty;
      bmrect_pkg::BK_RUN:   issue    = 1'b1;
      bmrect_pkg::BK_DRAIN: ;
      bmrect_pkg::BK_DONE:  res_push = ~res_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= bmrect_pkg::BK_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cq_pop) begin
      cur_r  <= cq_cmd;
      row_r  <= cq_cmd.row_lo;
      word_r <= cq_cmd.word_lo;
    end else if (issue) begin
      if (word_r == cur_r.word_hi) begin
        word_r <= cur_r.word_lo;
        row_r  <= row_r + 1'b1;
      end else begin
        word_r <= word_r + 1'b1;
      end
    end
  end

  always_comb begin
    lo_bit = (word_r == cur_r.word_lo) ? cur_r.bit_lo : '0;
    hi_bit = (word_r == cur_r.word_hi) ? cur_r.bit_hi : bmrect_pkg::BIT_MAX;
    mask   = ({bmrect_pkg::WORD_BITS{1'b1}} << lo_bit) &
             ({bmrect_pkg::WORD_BITS{1'b1}} >> (bmrect_pkg::BIT_MAX - hi_bit));
  end

  always_comb begin
    case (cur_r.op)
      bmrect_pkg::OP_SET:    new_word = rd_data_r | s1_mask_r;
      bmrect_pkg::OP_CLEAR:  new_word = rd_data_r & ~s1_mask_r;
      bmrect_pkg::OP_INVERT: new_word = rd_data_r ^ s1_mask_r;
      default:               new_word = rd_data_r;
    endcase
    gain = new_word & ~rd_data_r;
    loss = rd_data_r & ~new_word;
  end

  assign mem_we = clearing | s1_valid_r;
  assign mem_wa = clearing ? clr_addr_r : s1_addr_r;
  assign mem_wd = clearing ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= cell_mem_r[{row_r, word_r}];
  end

  always_comb begin
    gain_pad = PAD_W'(gain_r);
    loss_pad = PAD_W'(loss_r);
    for (int i = 0; i < NCHUNK; i++) begin
      gcnt[i] = '0;
      lcnt[i] = '0;
      for (int b = 0; b < 8; b++) begin
        gcnt[i] = gcnt[i] + 4'(gain_pad[i * 8 + b]);
        lcnt[i] = lcnt[i] + 4'(loss_pad[i * 8 + b]);
      end
    end
  end

  always_comb begin
    g_sum = '0;
    l_sum = '0;
    for (int i = 0; i < NCHUNK; i++) begin
      g_sum = g_sum + bmrect_pkg::PC_W'(gcnt_r[i]);
      l_sum = l_sum + bmrect_pkg::PC_W'(lcnt_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      total_r    <= '0;
    end else begin
      s1_valid_r <= issue;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      if (s3_valid_r) begin
        total_r <= total_r + bmrect_pkg::TOTAL_W'(g_sum) - bmrect_pkg::TOTAL_W'(l_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_mask_r <= mask;
    s1_addr_r <= {row_r, word_r};
    gain_r    <= gain;
    loss_r    <= loss;
    for (int i = 0; i < NCHUNK; i++) begin
      gcnt_r[i] <= gcnt[i];
      lcnt_r[i] <= lcnt[i];
    end
  end

  always_comb begin
    total_x   = bmrect_pkg::SAT_W'(total_r);
    sat_count = (total_x > bmrect_pkg::SAT_W'(bmrect_pkg::COUNT_MAX)) ?
                bmrect_pkg::COUNT_MAX : bmrect_pkg::OUT_W'(total_x);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rq_wr_r  <= '0;
      rq_rd_r  <= '0;
      rq_cnt_r <= '0;
    end else begin
      if (res_push) begin
        rq_wr_r <= rq_wr_r + 1'b1;
      end
      if (res_pop) begin
        rq_rd_r <= rq_rd_r + 1'b1;
      end
      if (res_push && !res_pop) begin
        rq_cnt_r <= rq_cnt_r + 1'b1;
      end else if (res_pop && !res_push) begin
        rq_cnt_r <= rq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_q_r[rq_wr_r] <= sat_count;
    end
  end

  // The count must be settled before a result is queued.
  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bmrect_pkg::BK_DONE) |-> !pipe_busy)
    else $error("result queued while word pipeline still busy");

  // Word updates belong only to a running command.
  a_pipe_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_busy |-> (state_r == bmrect_pkg::BK_RUN || state_r == bmrect_pkg::BK_DRAIN))
    else $error("word pipeline active outside a command");

  // No command is taken during the clearing pass.
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> (!cq_pop && !s1_valid_r))
    else $error("command work during clearing pass");

  // Each finished command yields exactly one queued result.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> (state_r == bmrect_pkg::BK_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

// ===== hw/rtl/bitmap_rectangle_set_clear_toggle_core.sv =====
// Top level of the one-bit raster rectangle set, clear and invert core.
//
//   channel  direction  transfer when          payload
//   in_      push side  in_push & !in_full     operation, two corner pairs
//   out_     pop side   out_pop & !out_empty   lit_count
//
// A command spanning R rows and W words of a row holds the sequencer while it is taken,
// while its R*W words issue, while the pipeline drains and while the result is queued;
// an empty or unused command goes from being taken straight to queuing its result.
// After reset a clearing pass writes all 16384 words, one a cycle, with in_full high.
// A full result queue holds the sequencer; commands still enter the front queue.
module bitmap_rectangle_set_clear_toggle_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [bmrect_pkg::OP_W-1:0]  in_operation,
  input  logic [bmrect_pkg::IN_W-1:0]  in_first_low,
  input  logic [bmrect_pkg::IN_W-1:0]  in_second_low,
  input  logic [bmrect_pkg::IN_W-1:0]  in_first_high,
  input  logic [bmrect_pkg::IN_W-1:0]  in_second_high,
  output logic                         out_empty,
  input  logic                         out_pop,
  output logic [bmrect_pkg::OUT_W-1:0] out_lit_count
);

  logic             clearing;
  logic             cq_full;
  logic             cq_push;
  logic             cq_empty;
  logic             cq_pop;
  bmrect_pkg::cmd_t fr_cmd;
  bmrect_pkg::cmd_t cq_head;

  bmrect_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_operation   (in_operation),
    .in_first_low   (in_first_low),
    .in_second_low  (in_second_low),
    .in_first_high  (in_first_high),
    .in_second_high (in_second_high),
    .clearing       (clearing),
    .cq_full        (cq_full),
    .cq_push        (cq_push),
    .cq_cmd         (fr_cmd)
  );

  bmrect_cmd_fifo u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .cmd_in  (fr_cmd),
    .full    (cq_full),
    .pop     (cq_pop),
    .empty   (cq_empty),
    .cmd_out (cq_head)
  );

  bmrect_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .clearing      (clearing),
    .cq_empty      (cq_empty),
    .cq_pop        (cq_pop),
    .cq_cmd        (cq_head),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_lit_count (out_lit_count)
  );

endmodule
